>>> sv/assert_macros.svh
// assertion macros shared by the rtl of the sparse checkpoint index
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define SCX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent holds -> consequent holds in the next cycle
`define SCX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// condition holds at every edge out of reset
`define SCX_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");

`endif

>>> sv/scx_pkg.sv
// shared types and constants of the sparse checkpoint index
// no dependencies
`timescale 1ns / 1ps

package scx_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int SEQ_W    = 32;
  localparam int SEG_W    = 32;
  localparam int OFF_W    = 64;
  localparam int ENTRY_W  = SEQ_W + SEG_W + OFF_W;
  localparam int PHASE_W  = 16;

  localparam logic [PHASE_W-1:0] INTERVAL_RESET = 16'd64;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_COUNTED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_HIT     = 3'd3,
    ST_MISS    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK0,
    S_SEARCH,
    S_FETCH
  } state_t;

endpackage

>>> sv/scx_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module scx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sparse_checkpoint_index.sv
// top level of the sparse checkpoint index: frame counting, checkpoint store, lookup search
// depends on scx_pkg, scx_ram and assert_macros.svh
`timescale 1ns / 1ps
//
// channel   direction  handshake           payload
// input     in         start, busy         in_mode, in_frame_*, in_target_sequence
// result    out        out_valid (strobe)  out_status, out_hit_*
// config    in         cfg_we              cfg_wdata (checkpoint interval)
//
// a frame item is handled in the cycle it is accepted and busy stays low, so frames may
// come back to back; each result strobes in the cycle after the accepting edge
// a lookup holds busy for the below-first check of entry 0, one ram read per halving
// step and, on a hit, the answer fetch; its result strobes in the first cycle with busy low
// a target below the first checkpoint is busy only in that check, an empty table not at all
// sync active-low reset clears count, phase and sequencer, presets interval, not the table;
// the receiver cannot stall: each result is on the out_ ports for exactly one cycle

`include "assert_macros.svh"

module sparse_checkpoint_index (
  input  logic                       clk,
  input  logic                       rst_n,
  // input item
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [scx_pkg::SEQ_W-1:0]  in_frame_sequence,
  input  logic [scx_pkg::SEG_W-1:0]  in_frame_segment,
  input  logic [scx_pkg::OFF_W-1:0]  in_frame_offset,
  input  logic [scx_pkg::SEQ_W-1:0]  in_target_sequence,
  // result item
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [scx_pkg::SEQ_W-1:0]  out_hit_sequence,
  output logic [scx_pkg::SEG_W-1:0]  out_hit_segment,
  output logic [scx_pkg::OFF_W-1:0]  out_hit_offset,
  // configuration
  input  logic                       cfg_we,
  input  logic [scx_pkg::PHASE_W-1:0] cfg_wdata
);

  localparam int CNT_W = scx_pkg::CNT_W;
  localparam int IDX_W = scx_pkg::IDX_W;

  // control state
  scx_pkg::state_t              state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [scx_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [scx_pkg::PHASE_W-1:0]  interval_r;
  logic                         out_valid_r, out_valid_nxt;

  // search registers
  logic [CNT_W-1:0]             lo_r, lo_nxt;
  logic [CNT_W-1:0]             hi_r, hi_nxt;
  logic [CNT_W-1:0]             mid_r, mid_nxt;
  logic [scx_pkg::SEQ_W-1:0]    target_r, target_nxt;

  // result payload
  scx_pkg::status_t             status_r, status_nxt;
  logic [scx_pkg::ENTRY_W-1:0]  hit_r, hit_nxt;

  // table port
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [scx_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  logic [scx_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [scx_pkg::SEQ_W-1:0]    rd_seq;

  logic                         accept;
  logic [scx_pkg::PHASE_W:0]    phase_inc;
  logic [CNT_W-1:0]             lo_step, hi_step, mid_step;
  logic                         below;

  scx_ram #(
    .WIDTH (scx_pkg::ENTRY_W),
    .DEPTH (scx_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != scx_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign rd_seq   = ram_rdata[scx_pkg::ENTRY_W-1 -: scx_pkg::SEQ_W];
  assign below    = (target_r < rd_seq);

  // one halving step of the search from the entry just read
  always_comb begin
    lo_step  = below ? lo_r : (mid_r + CNT_W'(1));
    hi_step  = below ? mid_r : hi_r;
    mid_step = lo_step + ((hi_step - lo_step) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scx_pkg::S_IDLE;
      count_r     <= '0;
      phase_r     <= '0;
      interval_r  <= scx_pkg::INTERVAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    target_r <= target_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    out_valid_nxt = 1'b0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    status_nxt    = status_r;
    hit_nxt       = '0;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = {in_frame_sequence, in_frame_segment, in_frame_offset};
    ram_raddr     = '0;
    phase_inc     = {1'b0, phase_r} + (scx_pkg::PHASE_W+1)'(1);

    unique case (state_r)
      scx_pkg::S_IDLE: begin
        if (accept && !in_mode) begin
          // frame: store on phase zero if there is room, then advance the phase
          out_valid_nxt = 1'b1;
          if (phase_r == '0) begin
            if (count_r < CNT_W'(scx_pkg::TABLE_DEPTH)) begin
              ram_we     = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = scx_pkg::ST_STORED;
            end else begin
              status_nxt = scx_pkg::ST_DROPPED;
            end
          end else begin
            status_nxt = scx_pkg::ST_COUNTED;
          end
          phase_nxt = (phase_inc >= {1'b0, interval_r}) ? '0
                                                        : phase_inc[scx_pkg::PHASE_W-1:0];
        end else if (accept && in_mode) begin
          target_nxt = in_target_sequence;
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = scx_pkg::ST_MISS;
          end else begin
            // read entry 0 for the below-first check
            ram_raddr = '0;
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = scx_pkg::S_CHK0;
          end
        end
      end

      scx_pkg::S_CHK0: begin
        if (below) begin
          out_valid_nxt = 1'b1;
          status_nxt    = scx_pkg::ST_MISS;
          state_nxt     = scx_pkg::S_IDLE;
        end else begin
          // first probe at the middle of [0, count)
          mid_nxt   = hi_r >> 1;
          ram_raddr = mid_nxt[IDX_W-1:0];
          state_nxt = scx_pkg::S_SEARCH;
        end
      end

      scx_pkg::S_SEARCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt   = mid_step;
          ram_raddr = mid_step[IDX_W-1:0];
        end else if (lo_step == '0) begin
          out_valid_nxt = 1'b1;
          status_nxt    = scx_pkg::ST_MISS;
          state_nxt     = scx_pkg::S_IDLE;
        end else begin
          // answer is the entry just below lo
          mid_nxt   = lo_step - CNT_W'(1);
          ram_raddr = mid_nxt[IDX_W-1:0];
          state_nxt = scx_pkg::S_FETCH;
        end
      end

      scx_pkg::S_FETCH: begin
        out_valid_nxt = 1'b1;
        status_nxt    = scx_pkg::ST_HIT;
        hit_nxt       = ram_rdata;
        state_nxt     = scx_pkg::S_IDLE;
      end

      default: begin
        state_nxt = scx_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_hit_sequence = hit_r[scx_pkg::ENTRY_W-1 -: scx_pkg::SEQ_W];
  assign out_hit_segment  = hit_r[scx_pkg::OFF_W +: scx_pkg::SEG_W];
  assign out_hit_offset   = hit_r[scx_pkg::OFF_W-1:0];

  // checks
  `SCX_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(scx_pkg::TABLE_DEPTH))
  `SCX_ASSERT_IMPL(a_write_idle, ram_we, state_r == scx_pkg::S_IDLE)
  `SCX_ASSERT_IMPL(a_search_window, state_r == scx_pkg::S_SEARCH,
                   lo_r <= mid_r && mid_r < hi_r && hi_r <= count_r)
  `SCX_ASSERT_IMPL(a_zero_fields, out_valid && out_status != scx_pkg::ST_HIT,
                   hit_r == '0)
  `SCX_ASSERT_NEXT(a_lookup_busy, accept && in_mode && count_r != '0, busy)

endmodule
